### rtl/core/wwsq_pkg.sv
// ----------------------------------------------------------------------------
// wwsq_pkg
// Shared sizes and codes for the windowed weighted square count query unit.
// ----------------------------------------------------------------------------
package wwsq_pkg;

    localparam int ARRAY_DEPTH = 4096;
    localparam int VALUE_BITS  = 16;

    localparam int INDEX_W  = 12;
    localparam int ELEM_W   = 16;
    localparam int POWER_W  = 40;

    localparam int ADDR_W   = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
    localparam int POS_W    = $clog2(ARRAY_DEPTH + 1);
    localparam int CNT_W    = POS_W;
    localparam int FACT_W   = CNT_W + 1;
    localparam int PROD_W   = FACT_W + VALUE_BITS;
    localparam int CMP_W    = ((INDEX_W > POS_W) ? INDEX_W : POS_W) + 1;
    localparam int VALUE_SPAN = 1 << VALUE_BITS;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [FACT_W-1:0]     fact_t;
    typedef logic [PROD_W-1:0]     prod_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [POWER_W-1:0]    power_t;

endpackage

### rtl/core/windowed_weighted_square_count_query_unit.sv
// ----------------------------------------------------------------------------
// windowed_weighted_square_count_query_unit
// Element store with a sliding window and value histogram; answers range
// queries with the sum of count squared times value.
// ----------------------------------------------------------------------------
// One item is in work at a time and req_ready is low meanwhile. A load, a
// refused load or an invalid query passes the decide state and then the
// final state, which loads the result and raises rsp_valid; a valid query
// passes the decide state, then S window steps (S is the distance moved by
// the window start plus the distance moved by the window end), then one more
// step state that finds the window in place, then the final state. Each step
// is a store read, a histogram read, one multiply with histogram write-back,
// and one add or subtract into the running sum, all on the single shared
// multiplier and accumulator. A finished result waits in an output register;
// req_ready returns as it is loaded, so a new transfer can then be taken, and
// a result still waiting there holds the unit in its final state. After reset
// the histogram memory is cleared one entry per cycle, all 2^VALUE_BITS =
// 65536 entries, before the first transfer.
module windowed_weighted_square_count_query_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_type,
    input  logic [wwsq_pkg::INDEX_W-1:0]  elem_index,
    input  logic [wwsq_pkg::ELEM_W-1:0]   elem_value,
    input  logic [wwsq_pkg::INDEX_W-1:0]  range_low,
    input  logic [wwsq_pkg::INDEX_W-1:0]  range_high,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [wwsq_pkg::POWER_W-1:0]  range_power,
    output logic                          bad_request
);
    import wwsq_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_STEP   = 3'd3;
    localparam logic [2:0] ST_VAL    = 3'd4;
    localparam logic [2:0] ST_CNT    = 3'd5;
    localparam logic [2:0] ST_ACC    = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    value_t store_mem [ARRAY_DEPTH];
    count_t count_mem [VALUE_SPAN];

    logic [2:0] state_reg, state_next;
    pos_t       ws_reg, ws_next;
    pos_t       we_reg, we_next;
    pos_t       stop_reg, stop_next;
    pos_t       lo_reg, lo_next;
    power_t     power_reg, power_next;
    value_t     clr_reg, clr_next;
    logic       out_valid_reg, out_valid_next;
    logic       bad_reg, bad_next;
    logic       add_reg, add_next;
    logic       skip_reg, skip_next;

    logic                 type_reg;
    logic [INDEX_W-1:0]   idx_reg;
    value_t               val_reg;
    logic [INDEX_W-1:0]   rlo_reg;
    logic [INDEX_W-1:0]   rhi_reg;
    value_t               elem_q_reg;
    count_t               cnt_q_reg;
    prod_t                prod_reg, prod_next;
    power_t               range_power_reg;
    logic                 bad_request_reg;

    logic   accept;
    logic   store_we;
    logic   rd_en;
    addr_t  rd_addr;
    logic   cnt_we;
    value_t cnt_waddr;
    count_t cnt_wdata;
    logic   out_load;
    cmp_t   idx_c, ws_c, we_c, rlo_c, rhi_c, depth_c, stop_c;
    fact_t  fact;

    assign req_ready   = (state_reg == ST_IDLE);
    assign accept      = req_valid && req_ready;
    assign rsp_valid   = out_valid_reg;
    assign range_power = range_power_reg;
    assign bad_request = bad_request_reg;

    assign idx_c   = cmp_t'(idx_reg);
    assign ws_c    = cmp_t'(ws_reg);
    assign we_c    = cmp_t'(we_reg);
    assign rlo_c   = cmp_t'(rlo_reg);
    assign rhi_c   = cmp_t'(rhi_reg);
    assign depth_c = cmp_t'(ARRAY_DEPTH);
    assign stop_c  = rhi_c + cmp_t'(1);

    always_comb
    begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        we_next        = we_reg;
        stop_next      = stop_reg;
        lo_next        = lo_reg;
        power_next     = power_reg;
        clr_next       = clr_reg;
        bad_next       = bad_reg;
        add_next       = add_reg;
        skip_next      = skip_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_load       = 1'b0;
        store_we       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        cnt_we         = 1'b0;
        cnt_waddr      = elem_q_reg;
        cnt_wdata      = cnt_q_reg;
        fact           = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + value_t'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                bad_next   = 1'b0;
                state_next = ST_FIN;
                if (type_reg == REQ_LOAD)
                begin
                    if (idx_c >= depth_c || (idx_c >= ws_c && idx_c < we_c))
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        store_we = 1'b1;
                    end
                end
                else if (rlo_c > rhi_c || rhi_c >= depth_c)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    stop_next  = stop_c[POS_W-1:0];
                    lo_next    = rlo_c[POS_W-1:0];
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = ST_VAL;
                rd_en      = 1'b1;
                if (we_reg < stop_reg)
                begin
                    rd_addr  = we_reg[ADDR_W-1:0];
                    add_next = 1'b1;
                    we_next  = we_reg + pos_t'(1);
                end
                else if (ws_reg > lo_reg)
                begin
                    rd_addr  = addr_t'(ws_reg - pos_t'(1));
                    add_next = 1'b1;
                    ws_next  = ws_reg - pos_t'(1);
                end
                else if (ws_reg < lo_reg)
                begin
                    rd_addr  = ws_reg[ADDR_W-1:0];
                    add_next = 1'b0;
                    ws_next  = ws_reg + pos_t'(1);
                end
                else if (we_reg > stop_reg)
                begin
                    rd_addr  = addr_t'(we_reg - pos_t'(1));
                    add_next = 1'b0;
                    we_next  = we_reg - pos_t'(1);
                end
                else
                begin
                    rd_en      = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_VAL:
            begin
                state_next = ST_CNT;
            end
            ST_CNT:
            begin
                if (add_reg)
                begin
                    fact      = {cnt_q_reg, 1'b1};
                    cnt_wdata = cnt_q_reg + count_t'(1);
                    skip_next = 1'b0;
                end
                else
                begin
                    fact      = {cnt_q_reg, 1'b0} - fact_t'(1);
                    cnt_wdata = cnt_q_reg - count_t'(1);
                    skip_next = (cnt_q_reg == '0);
                end
                cnt_we     = !skip_next;
                prod_next  = prod_t'(fact) * prod_t'(elem_q_reg);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!skip_reg)
                begin
                    if (add_reg)
                    begin
                        power_next = power_reg + power_t'(prod_reg);
                    end
                    else
                    begin
                        power_next = power_reg - power_t'(prod_reg);
                    end
                end
                state_next = ST_STEP;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ws_reg        <= '0;
            we_reg        <= '0;
            stop_reg      <= '0;
            lo_reg        <= '0;
            power_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            bad_reg       <= 1'b0;
            add_reg       <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            we_reg        <= we_next;
            stop_reg      <= stop_next;
            lo_reg        <= lo_next;
            power_reg     <= power_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            bad_reg       <= bad_next;
            add_reg       <= add_next;
            skip_reg      <= skip_next;
        end
    end

    // request payload and result data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req_type;
            idx_reg  <= elem_index;
            val_reg  <= elem_value[VALUE_BITS-1:0];
            rlo_reg  <= range_low;
            rhi_reg  <= range_high;
        end
        prod_reg <= prod_next;
        if (out_load)
        begin
            range_power_reg <= power_reg;
            bad_request_reg <= bad_reg;
        end
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[idx_reg[ADDR_W-1:0]] <= val_reg;
        end
        if (rd_en)
        begin
            elem_q_reg <= store_mem[rd_addr];
        end
    end

    // value histogram
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q_reg <= count_mem[elem_q_reg];
    end

    a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        ws_reg <= we_reg)
        else $error("window start passed window end");

    a_window_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        we_reg <= pos_t'(ARRAY_DEPTH))
        else $error("window end beyond store depth");

    a_power_only_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_ACC |=> $stable(power_reg))
        else $error("running sum changed outside accumulate");

    a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |=> !out_valid_reg)
        else $error("result produced during histogram clear");

endmodule

### sim/windowed_weighted_square_count_query_unit_test.sv
// ----------------------------------------------------------------------------
// windowed_weighted_square_count_query_unit_test
// Self-checking bench for the range query unit. A shadow of the element
// store, value histogram and window predicts every range power and refusal
// flag. Loads and queries run through three idle patterns, and a long
// response hold-off backs the unit up.
// ----------------------------------------------------------------------------
module windowed_weighted_square_count_query_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wwsq_pkg::*;

    localparam int ZONE = 256;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] idx;
        logic [ELEM_W-1:0]  val;
        logic [INDEX_W-1:0] lo;
        logic [INDEX_W-1:0] hi;
    } request_t;

    typedef struct packed {
        power_t power;
        logic   bad;
    } window_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic               req_type = REQ_LOAD;
    logic [INDEX_W-1:0] elem_index = '0;
    logic [ELEM_W-1:0]  elem_value = '0;
    logic [INDEX_W-1:0] range_low = '0;
    logic [INDEX_W-1:0] range_high = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic [POWER_W-1:0] range_power;
    logic               bad_request;

    request_t       request_backlog [$];
    window_result_t expected_answers [$];

    value_t      store_mem [ARRAY_DEPTH];
    int unsigned hist [VALUE_SPAN];
    int          win_start = 0;
    int          win_end = 0;
    power_t      power_acc = '0;

    bit gen_written [ARRAY_DEPTH];
    int gen_lo = 0;
    int gen_hi = 0;

    int     send_idle_pct = 30;
    int     recv_idle_pct = 88;
    int     phase_id = 0;
    logic   rx_hold = 1'b0;
    int     mismatches = 0;
    int     n_checked = 0;
    int     n_loads = 0;
    int     n_refused = 0;
    int     n_queries = 0;
    int     n_invalid = 0;
    int     widest = 0;
    power_t peak_power = '0;

    windowed_weighted_square_count_query_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .elem_index  (elem_index),
        .elem_value  (elem_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .range_power (range_power),
        .bad_request (bad_request)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void add_elem(int pos);
        value_t          v;
        longint unsigned c;
        v = store_mem[pos];
        c = hist[v];
        power_acc = power_t'(power_acc + (2 * c + 1) * v);
        hist[v] = hist[v] + 1;
    endfunction

    function automatic void drop_elem(int pos);
        value_t          v;
        longint unsigned c;
        v = store_mem[pos];
        c = hist[v];
        if (c != 0)
        begin
            power_acc = power_t'(power_acc - (2 * c - 1) * v);
            hist[v] = hist[v] - 1;
        end
    endfunction

    function automatic window_result_t answer_request(request_t rq);
        window_result_t res;
        int             stop;
        res.bad = 1'b0;
        if (rq.kind == REQ_LOAD)
        begin
            n_loads++;
            if (int'(rq.idx) >= ARRAY_DEPTH || (int'(rq.idx) >= win_start && int'(rq.idx) < win_end))
            begin
                res.bad = 1'b1;
                n_refused++;
            end
            else
                store_mem[rq.idx] = value_t'(rq.val);
        end
        else
        begin
            n_queries++;
            if (rq.lo > rq.hi || int'(rq.hi) >= ARRAY_DEPTH)
            begin
                res.bad = 1'b1;
                n_invalid++;
            end
            else
            begin
                stop = int'(rq.hi) + 1;
                while (win_end < stop)
                begin
                    add_elem(win_end);
                    win_end++;
                end
                while (win_start > int'(rq.lo))
                begin
                    win_start--;
                    add_elem(win_start);
                end
                while (win_start < int'(rq.lo))
                begin
                    drop_elem(win_start);
                    win_start++;
                end
                while (win_end > stop)
                begin
                    win_end--;
                    drop_elem(win_end);
                end
                if (win_end - win_start > widest)
                    widest = win_end - win_start;
            end
        end
        res.power = power_acc;
        if (power_acc > peak_power)
            peak_power = power_acc;
        return res;
    endfunction

    // sender: one transfer per handshake, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin : feed
        request_t nxt;
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req_type   <= REQ_LOAD;
            elem_index <= '0;
            elem_value <= '0;
            range_low  <= '0;
            range_high <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_answers.push_back(answer_request({req_type, elem_index, elem_value,
                                                           range_low, range_high}));
            if (!req_valid || req_ready)
            begin
                if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = request_backlog.pop_front();
                    req_valid  <= 1'b1;
                    req_type   <= nxt.kind;
                    elem_index <= nxt.idx;
                    elem_value <= nxt.val;
                    range_low  <= nxt.lo;
                    range_high <= nxt.hi;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : sink
        window_result_t exp_res;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                n_checked++;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing pending: power %0d bad %0b",
                                 $realtime, range_power, bad_request);
                end
                else
                begin
                    exp_res = expected_answers.pop_front();
                    if (range_power !== exp_res.power || bad_request !== exp_res.bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: power %0d/%0d bad %0b/%0b (exp/act)",
                                     $realtime, exp_res.power, range_power,
                                     exp_res.bad, bad_request);
                    end
                end
            end
            rsp_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic post_request(input logic kind, input int idx, input int val,
                                input int lo, input int hi);
        request_t rq;
        rq.kind = kind;
        rq.idx  = INDEX_W'(idx);
        rq.val  = ELEM_W'(val);
        rq.lo   = INDEX_W'(lo);
        rq.hi   = INDEX_W'(hi);
        if (kind == REQ_LOAD)
        begin
            if (!(int'(rq.idx) >= gen_lo && int'(rq.idx) < gen_hi))
                gen_written[rq.idx] = 1'b1;
        end
        else if (rq.lo <= rq.hi)
        begin
            gen_lo = int'(rq.lo);
            gen_hi = int'(rq.hi) + 1;
        end
        request_backlog.push_back(rq);
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 3;
            3: return 16'hFFFF;
            4: return 16'hFFFE;
            default: return int'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // mostly queries near the current window inside a written zone;
    // a query that would walk over unwritten entries becomes a fill load
    task automatic post_random(input int count);
        int r;
        int idx;
        int lo;
        int hi;
        int span_lo;
        int span_hi;
        int gap;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                if ($urandom_range(0, 4) == 0)
                    idx = $urandom_range(0, ARRAY_DEPTH - 1);
                else
                    idx = $urandom_range(0, ZONE - 1);
                post_request(REQ_LOAD, idx, pick_value(), $urandom, $urandom);
            end
            else if (r < 90)
            begin
                lo = gen_lo + $urandom_range(0, 48) - 24;
                if (lo < 0)
                    lo = 0;
                if (lo > ZONE - 1)
                    lo = ZONE - 1;
                if ($urandom_range(0, 19) == 0)
                    hi = lo + $urandom_range(0, ZONE - 1);
                else
                    hi = lo + $urandom_range(0, 40);
                if (hi > ZONE - 1)
                    hi = ZONE - 1;
                span_lo = (gen_lo < lo) ? gen_lo : lo;
                span_hi = (gen_hi > hi + 1) ? gen_hi : hi + 1;
                gap = -1;
                for (int p = span_lo; p < span_hi && gap < 0; p++)
                    if (!gen_written[p])
                        gap = p;
                if (gap >= 0)
                    post_request(REQ_LOAD, gap, pick_value(), $urandom, $urandom);
                else
                    post_request(REQ_QUERY, $urandom, $urandom, lo, hi);
            end
            else
            begin
                hi = $urandom_range(0, ARRAY_DEPTH - 2);
                lo = $urandom_range(hi + 1, ARRAY_DEPTH - 1);
                post_request(REQ_QUERY, $urandom, $urandom, lo, hi);
            end
        end
    endtask

    task automatic wait_drained();
        while (request_backlog.size() != 0 || req_valid || expected_answers.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : rx_hold_off
        wait (phase_id == 3);
        repeat (40) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        phase_id = 1;
        post_request(REQ_LOAD, 0, 0, 0, 0);
        post_request(REQ_LOAD, 1, 16'hFFFF, 4095, 4095);
        post_request(REQ_LOAD, 2, 16'hFFFF, 0, 0);
        post_request(REQ_LOAD, 3, 1, 0, 0);
        post_request(REQ_LOAD, 4, 16'hFFFF, 0, 0);
        post_request(REQ_LOAD, 5, 16'h8000, 0, 0);
        post_request(REQ_LOAD, 6, 1, 0, 0);
        post_request(REQ_LOAD, 7, 16'h7FFF, 0, 0);
        post_request(REQ_LOAD, 4095, 16'hFFFF, 0, 0);
        post_request(REQ_QUERY, 0, 0, 0, 0);
        post_request(REQ_QUERY, 4095, 16'hFFFF, 0, 4);
        post_request(REQ_QUERY, 0, 0, 2, 7);
        post_request(REQ_QUERY, 0, 0, 1, 3);
        // window is [1,4): start is refused, end is exclusive, below start is open
        post_request(REQ_LOAD, 1, 5, 0, 0);
        post_request(REQ_LOAD, 3, 5, 0, 0);
        post_request(REQ_LOAD, 4, 16'hFFFF, 0, 0);
        post_request(REQ_LOAD, 0, 16'hAAAA, 0, 0);
        post_request(REQ_QUERY, 0, 0, 5, 4);
        post_request(REQ_QUERY, 0, 0, 4095, 0);
        post_request(REQ_QUERY, 0, 0, 3, 3);
        post_request(REQ_QUERY, 0, 0, 0, 7);
        post_random(200);
        wait_drained();

        phase_id = 2;
        send_idle_pct = 88;
        recv_idle_pct = 30;
        post_random(200);
        wait_drained();

        phase_id = 3;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        post_random(200);
        wait_drained();

        repeat (20) @(posedge clk);
        mismatches += expected_answers.size();
        $display("checked %0d results: %0d loads (%0d refused), %0d queries (%0d invalid)",
                 n_checked, n_loads, n_refused, n_queries, n_invalid);
        $display("widest window %0d elements, peak range power %0d", widest, peak_power);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #60_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
rtl/core/wwsq_pkg.sv
rtl/core/windowed_weighted_square_count_query_unit.sv
sim/windowed_weighted_square_count_query_unit_test.sv
